/* src/avm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_pkg
// Shared types and constants of the averaging voltmeter with display and PWM.
// ----------------------------------------------------------------------------
package avm_pkg;

   parameter int SAMPLES_PER_AVERAGE = 4;

   localparam int SampleW = 10;
   localparam int SumW    = SampleW + $clog2(SAMPLES_PER_AVERAGE);
   localparam int CntW    = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
   localparam int VoltW   = 6;
   localparam int PeriodW = 16;
   localparam int DutyW   = 8;
   localparam int ProdW   = PeriodW + DutyW;
   localparam int ScaleW  = 16;
   localparam int SegW    = 7;
   localparam int DigW    = 2;

   localparam int DivNumW  = ProdW;
   localparam int DivDenW  = 10;
   localparam int DivQW    = 16;
   localparam int RecipW   = 24;
   localparam int DivProdW = DivNumW + RecipW;

   localparam logic [PeriodW-1:0] PeriodReset  = 16'd50000;
   localparam logic [DivDenW-1:0] FullScale    = 10'd1023;
   localparam logic [DivDenW-1:0] Percent      = 10'd100;
   localparam logic [ScaleW-1:0]  VoltScale    = 16'd33;
   localparam logic [ScaleW-1:0]  VoltRound    = 16'd511;
   localparam logic [DutyW-1:0]   DutyPerTenth = 8'd3;
   localparam logic [DutyW-1:0]   DutyLimit    = 8'd100;

   // reciprocal divides, exact over each numerator range
   localparam int AvgShift  = SumW + 4;
   localparam int VoltShift = 26;
   localparam int PwmShift  = 30;
   localparam logic [RecipW-1:0] AvgRecip = RecipW'(((64'd1 << AvgShift) +
      64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE));
   localparam logic [RecipW-1:0] VoltRecip = RecipW'(((64'd1 << VoltShift) +
      64'(FullScale) - 64'd1) / 64'(FullScale));
   localparam logic [RecipW-1:0] PwmRecip = RecipW'(((64'd1 << PwmShift) +
      64'(Percent) - 64'd1) / 64'(Percent));

   localparam logic [1:0] SwMeasure = 2'd0;
   localparam logic [1:0] SwFreeze  = 2'd1;

   localparam logic [DigW-1:0] DigNone = 2'd0;
   localparam logic [DigW-1:0] DigLow  = 2'd1;
   localparam logic [DigW-1:0] DigHigh = 2'd2;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_MODE   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      DIV_AVG,
      DIV_VOLT,
      DIV_PWM
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_SCALE,
      ST_VOLT_START,
      ST_VOLT_WAIT,
      ST_PWM_START,
      ST_PWM_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        div_start;
      div_sel_type div_sel;
      logic        load_scale;
      logic        write_volt;
      logic        write_cmp;
   } cmd_type;

   typedef struct packed {
      logic avg_go;
      logic pwm_go;
      logic div_busy;
   } stat_type;

endpackage

/* src/avm_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_req_if
// Event channel: opcode, converter sample and mode switches.
// ----------------------------------------------------------------------------
interface avm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [9:0] sample_value;
   logic [1:0] switches;

   modport source (output valid, output opcode, output sample_value, output switches,
                   input ready);
   modport sink (input valid, input opcode, input sample_value, input switches,
                 output ready);
endinterface

/* src/avm_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_rsp_if
// Result channel: display drive, PWM compare and averaged voltage.
// ----------------------------------------------------------------------------
interface avm_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  segments;
   logic [1:0]  digit_enable;
   logic [15:0] pwm_compare;
   logic [5:0]  voltage;
   logic        voltage_updated;

   modport source (output valid, output segments, output digit_enable,
                   output pwm_compare, output voltage, output voltage_updated,
                   input ready);
   modport sink (input valid, input segments, input digit_enable,
                 input pwm_compare, input voltage, input voltage_updated,
                 output ready);
endinterface

/* src/averaging_voltmeter_display_pwm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaging_voltmeter_display_pwm
// Averaging voltmeter with 7-segment display drive and PWM compare output.
// A sample that closes a group runs two reciprocal-multiply divides by
// constants plus a scale step; a PWM update runs one divide. One
// transaction in flight at a time.
// Synchronous active-high reset; period resets to 50000, measuring enabled.
// ----------------------------------------------------------------------------
module averaging_voltmeter_display_pwm
   import avm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   avm_req_if.sink            req_chan,
   avm_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [PeriodW-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   avm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   avm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .opcode          (req_chan.opcode),
      .sample_value    (req_chan.sample_value),
      .switches        (req_chan.switches),
      .segments        (rsp_chan.segments),
      .digit_enable    (rsp_chan.digit_enable),
      .pwm_compare     (rsp_chan.pwm_compare),
      .voltage         (rsp_chan.voltage),
      .voltage_updated (rsp_chan.voltage_updated)
   );

endmodule

/* src/avm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_div
// Shared divide by a constant: reciprocal multiply registered in the cycle
// after start, quotient shifted out and registered in the cycle after that.
// ----------------------------------------------------------------------------
module avm_div
   import avm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  div_sel_type        sel,
   input  logic [DivNumW-1:0] num,
   output logic               busy,
   output logic [DivQW-1:0]   quot
);

   logic [DivProdW-1:0] prod_ff, prod_in;
   div_sel_type         sel_ff, sel_in;
   logic                pend_ff, pend_in;
   logic [DivQW-1:0]    q_ff, q_in;
   logic [RecipW-1:0]   recip;
   logic [DivQW-1:0]    shifted;

   always_comb begin
      case (sel)
         DIV_AVG:  recip = AvgRecip;
         DIV_VOLT: recip = VoltRecip;
         default:  recip = PwmRecip;
      endcase
   end

   always_comb begin
      case (sel_ff)
         DIV_AVG:  shifted = DivQW'(prod_ff >> AvgShift);
         DIV_VOLT: shifted = DivQW'(prod_ff >> VoltShift);
         default:  shifted = DivQW'(prod_ff >> PwmShift);
      endcase
   end

   always_comb begin
      prod_in = prod_ff;
      sel_in  = sel_ff;
      pend_in = 1'b0;
      q_in    = q_ff;
      if (start) begin
         prod_in = DivProdW'(num) * DivProdW'(recip);
         sel_in  = sel;
         pend_in = 1'b1;
      end
      if (pend_ff) begin
         q_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      prod_ff <= prod_in;
      sel_ff  <= sel_in;
      q_ff    <= q_in;
   end

   assign busy = pend_ff;
   assign quot = q_ff;

endmodule

/* src/avm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_dp
// Datapath: sample accumulator, voltage scaling, display drive, mode and
// PWM compare registers, with the shared divider.
// ----------------------------------------------------------------------------
module avm_dp
   import avm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               csr_wr_en,
   input  logic [PeriodW-1:0] csr_wr_data,
   input  logic [1:0]         opcode,
   input  logic [SampleW-1:0] sample_value,
   input  logic [1:0]         switches,
   output logic [SegW-1:0]    segments,
   output logic [DigW-1:0]    digit_enable,
   output logic [PeriodW-1:0] pwm_compare,
   output logic [VoltW-1:0]   voltage,
   output logic               voltage_updated
);

   function automatic logic [SegW-1:0] seg_code(input logic [3:0] d);
      logic [SegW-1:0] s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

   logic [PeriodW-1:0] period_ff, period_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [VoltW-1:0]   volt_ff, volt_in;
   logic               high_ff, high_in;
   logic [SegW-1:0]    seg_ff, seg_in;
   logic [DigW-1:0]    dig_ff, dig_in;
   logic [PeriodW-1:0] cmp_ff, cmp_in;
   logic               meas_ff, meas_in;
   logic               upd_ff, upd_in;
   logic [ProdW-1:0]   prod_ff, prod_in;
   logic [ScaleW-1:0]  scale_ff, scale_in;

   opcode_type         op;
   logic [DutyW-1:0]   duty;
   logic [3:0]         tens;
   logic [3:0]         units;
   logic               last;

   logic [DivNumW-1:0] div_num;
   logic               div_busy;
   logic [DivQW-1:0]   div_quot;

   assign op   = opcode_type'(opcode);
   assign duty = DutyW'(volt_ff) * DutyPerTenth;
   assign last = cnt_ff == CntW'(SAMPLES_PER_AVERAGE - 1);

   always_comb begin
      if (volt_ff >= 6'd60)      tens = 4'd6;
      else if (volt_ff >= 6'd50) tens = 4'd5;
      else if (volt_ff >= 6'd40) tens = 4'd4;
      else if (volt_ff >= 6'd30) tens = 4'd3;
      else if (volt_ff >= 6'd20) tens = 4'd2;
      else if (volt_ff >= 6'd10) tens = 4'd1;
      else                       tens = 4'd0;
      units = 4'(volt_ff - VoltW'(tens) * 6'd10);
   end

   assign stat.avg_go   = (op == OP_SAMPLE) && meas_ff && last;
   assign stat.pwm_go   = (op == OP_MODE) && !(switches inside {SwMeasure, SwFreeze}) &&
                          (duty != '0) && (duty < DutyLimit);
   assign stat.div_busy = div_busy;

   always_comb begin
      case (cmd.div_sel)
         DIV_AVG:  div_num = DivNumW'(sum_ff);
         DIV_VOLT: div_num = DivNumW'(scale_ff);
         default:  div_num = prod_ff;
      endcase
   end

   avm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .sel   (cmd.div_sel),
      .num   (div_num),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   always_comb begin
      period_in = csr_wr_en ? csr_wr_data : period_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      volt_in   = volt_ff;
      high_in   = high_ff;
      seg_in    = seg_ff;
      dig_in    = dig_ff;
      cmp_in    = cmp_ff;
      meas_in   = meas_ff;
      upd_in    = upd_ff;
      prod_in   = prod_ff;
      scale_in  = scale_ff;
      if (cmd.accept) begin
         upd_in  = 1'b0;
         prod_in = ProdW'(period_ff) * ProdW'(duty);
         case (op)
            OP_SAMPLE: begin
               if (meas_ff) begin
                  sum_in = sum_ff + SumW'(sample_value);
                  cnt_in = last ? '0 : cnt_ff + 1'b1;
               end
            end
            OP_TICK: begin
               high_in = !high_ff;
               seg_in  = high_ff ? seg_code(tens) : seg_code(units);
               dig_in  = high_ff ? DigHigh : DigLow;
            end
            OP_MODE: begin
               meas_in = switches != SwFreeze;
            end
            default: begin
            end
         endcase
      end
      if (cmd.load_scale) begin
         scale_in = ScaleW'(div_quot[SampleW-1:0]) * VoltScale + VoltRound;
      end
      if (cmd.write_volt) begin
         volt_in = div_quot[VoltW-1:0];
         sum_in  = '0;
         upd_in  = 1'b1;
      end
      if (cmd.write_cmp) begin
         cmp_in = div_quot[PeriodW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PeriodReset;
         sum_ff    <= '0;
         cnt_ff    <= '0;
         volt_ff   <= '0;
         high_ff   <= 1'b0;
         seg_ff    <= '0;
         dig_ff    <= DigNone;
         cmp_ff    <= '0;
         meas_ff   <= 1'b1;
         upd_ff    <= 1'b0;
      end else begin
         period_ff <= period_in;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
         volt_ff   <= volt_in;
         high_ff   <= high_in;
         seg_ff    <= seg_in;
         dig_ff    <= dig_in;
         cmp_ff    <= cmp_in;
         meas_ff   <= meas_in;
         upd_ff    <= upd_in;
      end
      prod_ff  <= prod_in;
      scale_ff <= scale_in;
   end

   assign segments        = seg_ff;
   assign digit_enable    = dig_ff;
   assign pwm_compare     = cmp_ff;
   assign voltage         = volt_ff;
   assign voltage_updated = upd_ff;

endmodule

/* src/avm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_ctrl
// Controller: accepts one transaction, sequences the divide and scale steps,
// then holds the result until it is taken.
// ----------------------------------------------------------------------------
module avm_ctrl
   import avm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (stat.avg_go)      state_in = ST_AVG_START;
               else if (stat.pwm_go) state_in = ST_PWM_START;
               else                  state_in = ST_RESP;
            end
         end
         ST_AVG_START:  state_in = ST_AVG_WAIT;
         ST_AVG_WAIT:   if (!stat.div_busy) state_in = ST_SCALE;
         ST_SCALE:      state_in = ST_VOLT_START;
         ST_VOLT_START: state_in = ST_VOLT_WAIT;
         ST_VOLT_WAIT:  if (!stat.div_busy) state_in = ST_RESP;
         ST_PWM_START:  state_in = ST_PWM_WAIT;
         ST_PWM_WAIT:   if (!stat.div_busy) state_in = ST_RESP;
         ST_RESP:       if (rsp_ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      cmd.div_sel    = DIV_AVG;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_AVG_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_AVG;
         end
         ST_SCALE: begin
            cmd.load_scale = 1'b1;
         end
         ST_VOLT_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VOLT;
         end
         ST_VOLT_WAIT: begin
            cmd.write_volt = !stat.div_busy;
         end
         ST_PWM_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_PWM;
         end
         ST_PWM_WAIT: begin
            cmd.write_cmp = !stat.div_busy;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* verif/averaging_voltmeter_display_pwm_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaging_voltmeter_display_pwm_tb
// Self-checking bench for the averaging voltmeter. A directed table covers
// reset state, full-scale and zero groups, freeze with a partial group, and
// the PWM duty window. Random events follow under several PWM periods
// (65535, 1, 0, 100, random) and stall mixes. Every response transaction is
// compared field by field with its table row or an in-bench voltmeter model.
// ----------------------------------------------------------------------------
module averaging_voltmeter_display_pwm_tb;
   import avm_pkg::*;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 330;
   localparam int DRAIN_CYCLES   = 30;
   localparam int MAX_REPORTS    = 40;

   localparam logic [1:0]         SW_PWM     = 2'd2;
   localparam logic [1:0]         SW_PWM_ALT = 2'd3;
   localparam logic [SampleW-1:0] SAMPLE_MAX = 10'd1023;
   localparam logic [SegW-1:0]    SEG_BLANK  = 7'h00;
   localparam logic [SegW-1:0]    SEG_0      = 7'h3F;
   localparam logic [SegW-1:0]    SEG_3      = 7'h4F;

   typedef struct packed {
      logic [SegW-1:0]    segments;
      logic [DigW-1:0]    digit_enable;
      logic [PeriodW-1:0] pwm_compare;
      logic [VoltW-1:0]   voltage;
      logic               voltage_updated;
   } reading_type;

   typedef struct packed {
      opcode_type         op;
      logic [SampleW-1:0] sample;
      logic [1:0]         sw;
      logic               typed;
      reading_type        want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [PeriodW-1:0] csr_wr_data;

   avm_req_if req ();
   avm_rsp_if rsp ();

   averaging_voltmeter_display_pwm u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // meter model state
   logic [SumW-1:0]    acc_sum;
   int                 acc_count;
   logic [VoltW-1:0]   volt_tenths;
   logic               high_next;
   logic [SegW-1:0]    seg_drive;
   logic [DigW-1:0]    dig_drive;
   logic [PeriodW-1:0] cmp_value;
   logic               measuring;
   logic [PeriodW-1:0] period_reg;

   reading_type pending_readings[$];
   int req_idle_pct;
   int rsp_idle_pct;
   int items_sent;
   int readings_checked = 0;
   int groups_closed = 0;
   int mismatches = 0;
   int cycle_count = 0;

   stim_row_type directed_rows [0:25] = '{
      '{OP_NONE,   SAMPLE_MAX, SW_PWM_ALT, 1'b1, '{SEG_BLANK, DigNone, 16'd0, 6'd0, 1'b0}},
      '{OP_TICK,   10'd0,      SwMeasure,  1'b1, '{SEG_0, DigLow,  16'd0, 6'd0, 1'b0}},
      '{OP_TICK,   10'd0,      SwMeasure,  1'b1, '{SEG_0, DigHigh, 16'd0, 6'd0, 1'b0}},
      '{OP_MODE,   10'd0,      SW_PWM,     1'b1, '{SEG_0, DigHigh, 16'd0, 6'd0, 1'b0}},
      '{OP_SAMPLE, SAMPLE_MAX, SwMeasure,  1'b1, '{SEG_0, DigHigh, 16'd0, 6'd0, 1'b0}},
      '{OP_SAMPLE, SAMPLE_MAX, SwMeasure,  1'b1, '{SEG_0, DigHigh, 16'd0, 6'd0, 1'b0}},
      '{OP_SAMPLE, SAMPLE_MAX, SwMeasure,  1'b1, '{SEG_0, DigHigh, 16'd0, 6'd0, 1'b0}},
      '{OP_SAMPLE, SAMPLE_MAX, SwMeasure,  1'b1, '{SEG_0, DigHigh, 16'd0, 6'd33, 1'b1}},
      '{OP_TICK,   10'd0,      SwMeasure,  1'b1, '{SEG_3, DigLow,  16'd0, 6'd33, 1'b0}},
      '{OP_TICK,   10'd0,      SwMeasure,  1'b1, '{SEG_3, DigHigh, 16'd0, 6'd33, 1'b0}},
      '{OP_MODE,   10'd0,      SW_PWM_ALT, 1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_MODE,   10'd0,      SwFreeze,   1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_SAMPLE, SAMPLE_MAX, SwMeasure,  1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_MODE,   10'd0,      SwMeasure,  1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_SAMPLE, 10'd0,      SwMeasure,  1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_SAMPLE, 10'd0,      SwMeasure,  1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_MODE,   10'd0,      SwFreeze,   1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_MODE,   10'd0,      SwMeasure,  1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_SAMPLE, 10'd0,      SwMeasure,  1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd33, 1'b0}},
      '{OP_SAMPLE, 10'd0,      SwMeasure,  1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd0, 1'b1}},
      '{OP_MODE,   10'd0,      SW_PWM,     1'b1, '{SEG_3, DigHigh, 16'd49500, 6'd0, 1'b0}},
      '{OP_SAMPLE, 10'd512,    SwMeasure,  1'b0, '0},
      '{OP_SAMPLE, 10'd511,    SwMeasure,  1'b0, '0},
      '{OP_SAMPLE, 10'd300,    SwMeasure,  1'b0, '0},
      '{OP_SAMPLE, 10'd700,    SwMeasure,  1'b0, '0},
      '{OP_MODE,   10'd0,      SW_PWM_ALT, 1'b0, '0}
   };

   function automatic logic [SegW-1:0] digit_segments(input int unsigned d);
      case (d)
         0: return 7'h3F;
         1: return 7'h06;
         2: return 7'h5B;
         3: return 7'h4F;
         4: return 7'h66;
         5: return 7'h6D;
         6: return 7'h7D;
         7: return 7'h07;
         8: return 7'h7F;
         default: return 7'h6F;
      endcase
   endfunction

   function automatic reading_type predict_reading(input opcode_type op,
                                                   input logic [SampleW-1:0] smp,
                                                   input logic [1:0] sw);
      reading_type r;
      int unsigned avg;
      int unsigned duty;
      int unsigned v;
      r.voltage_updated = 1'b0;
      case (op)
         OP_SAMPLE: begin
            if (measuring) begin
               acc_sum = acc_sum + SumW'(smp);
               acc_count++;
               if (acc_count >= SAMPLES_PER_AVERAGE) begin
                  avg = 32'(acc_sum) / 32'(SAMPLES_PER_AVERAGE);
                  volt_tenths = VoltW'((avg * 32'(VoltScale) + 32'(VoltRound)) /
                                       32'(FullScale));
                  acc_sum = '0;
                  acc_count = 0;
                  r.voltage_updated = 1'b1;
               end
            end
         end
         OP_TICK: begin
            v = 32'(volt_tenths) % 100;
            if (!high_next) begin
               seg_drive = digit_segments(v % 10);
               dig_drive = DigLow;
            end else begin
               seg_drive = digit_segments(v / 10);
               dig_drive = DigHigh;
            end
            high_next = ~high_next;
         end
         OP_MODE: begin
            if (sw == SwFreeze) begin
               measuring = 1'b0;
            end else begin
               measuring = 1'b1;
               if (sw != SwMeasure) begin
                  duty = 32'(volt_tenths) * 32'(DutyPerTenth);
                  if (duty > 0 && duty < 32'(DutyLimit))
                     cmp_value = PeriodW'((32'(period_reg) * duty) / 32'(Percent));
               end
            end
         end
         default: ;
      endcase
      r.segments     = seg_drive;
      r.digit_enable = dig_drive;
      r.pwm_compare  = cmp_value;
      r.voltage      = volt_tenths;
      return r;
   endfunction

   task automatic offer(input opcode_type op, input logic [SampleW-1:0] smp,
                        input logic [1:0] sw);
      req.valid        <= 1'b1;
      req.opcode       <= op;
      req.sample_value <= smp;
      req.switches     <= sw;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic idle_gap();
      while ($urandom_range(99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_period(input logic [PeriodW-1:0] p);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      period_reg  = p;
   endtask

   always @(posedge clock) begin : rsp_monitor
      reading_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            $error("response transaction with nothing expected");
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (rsp.voltage_updated === 1'b1) groups_closed++;
            if (rsp.segments !== want.segments) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $error("segments: expected %0h, got %0h", want.segments, rsp.segments);
            end
            if (rsp.digit_enable !== want.digit_enable) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $error("digit_enable: expected %0d, got %0d",
                         want.digit_enable, rsp.digit_enable);
            end
            if (rsp.pwm_compare !== want.pwm_compare) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $error("pwm_compare: expected %0d, got %0d",
                         want.pwm_compare, rsp.pwm_compare);
            end
            if (rsp.voltage !== want.voltage) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $error("voltage: expected %0d, got %0d", want.voltage, rsp.voltage);
            end
            if (rsp.voltage_updated !== want.voltage_updated) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $error("voltage_updated: expected %0d, got %0d",
                         want.voltage_updated, rsp.voltage_updated);
            end
         end
      end
      rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      opcode_type         op;
      logic [SampleW-1:0] smp;
      logic [1:0]         sw;
      logic [PeriodW-1:0] phase_period;
      int                 pick;
      reading_type        r;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req.valid        = 1'b0;
      req.opcode       = OP_SAMPLE;
      req.sample_value = '0;
      req.switches     = SwMeasure;
      items_sent       = 0;
      req_idle_pct     = 20;
      rsp_idle_pct     = 88;

      acc_sum     = '0;
      acc_count   = 0;
      volt_tenths = '0;
      high_next   = 1'b0;
      seg_drive   = '0;
      dig_drive   = DigNone;
      cmp_value   = '0;
      measuring   = 1'b1;
      period_reg  = PeriodReset;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer(directed_rows[i].op, directed_rows[i].sample, directed_rows[i].sw);
         r = predict_reading(directed_rows[i].op, directed_rows[i].sample,
                             directed_rows[i].sw);
         pending_readings.push_back(directed_rows[i].typed ? directed_rows[i].want : r);
         idle_gap();
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: phase_period = 16'hFFFF;
            1: phase_period = 16'd1;
            2: phase_period = 16'd0;
            4: phase_period = 16'd100;
            default: phase_period = PeriodW'($urandom_range(65534, 2));
         endcase
         write_period(phase_period);
         if (ph < 2) begin
            req_idle_pct = 20;
            rsp_idle_pct = 88;
         end else if (ph < 4) begin
            req_idle_pct = 88;
            rsp_idle_pct = 20;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 55)      op = OP_SAMPLE;
            else if (pick < 75) op = OP_TICK;
            else if (pick < 95) op = OP_MODE;
            else                op = OP_NONE;
            pick = $urandom_range(9);
            if (pick == 0)      smp = '0;
            else if (pick == 1) smp = SAMPLE_MAX;
            else                smp = SampleW'($urandom_range(1023));
            pick = $urandom_range(99);
            if (pick < 20)      sw = SwMeasure;
            else if (pick < 35) sw = SwFreeze;
            else if (pick < 68) sw = SW_PWM;
            else                sw = SW_PWM_ALT;
            offer(op, smp, sw);
            pending_readings.push_back(predict_reading(op, smp, sw));
            idle_gap();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d event transactions, checked %0d readings, %0d averaging groups.",
               items_sent, readings_checked, groups_closed);
      $display("PWM periods 50000, 65535, 1, 0, 100 and random; stalls 20/88, 88/20, none.");
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
src/avm_pkg.sv
src/avm_req_if.sv
src/avm_rsp_if.sv
src/avm_div.sv
src/avm_dp.sv
src/avm_ctrl.sv
src/averaging_voltmeter_display_pwm.sv
verif/averaging_voltmeter_display_pwm_tb.sv
